[sv/hst_pkg.sv]
// Shared constants, codes and control structs of the handle slot table.
`default_nettype none
package hst_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIVE_W = $clog2(SLOTS + 1);

  // Field widths fixed by the interface
  localparam int REQ_W = 3;
  localparam int HANDLE_W = 32;
  localparam int EXIT_W = 32;
  localparam int SLOTNUM_W = 8;
  localparam int SLOT_OUT_W = 4;
  localparam int LIVE_OUT_W = 5;
  localparam int STATE_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FIND     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_EXIT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FREE     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_MARK_RUN = 3'd5;

  // Slot states
  localparam logic [STATE_W-1:0] ST_FREE    = 2'd0;
  localparam logic [STATE_W-1:0] ST_LOADING = 2'd1;
  localparam logic [STATE_W-1:0] ST_RUNNING = 2'd2;
  localparam logic [STATE_W-1:0] ST_EXITED  = 2'd3;

  localparam logic [HANDLE_W-1:0] HANDLE_RESET = 32'd1;

  typedef struct packed {
    logic capture;
    logic execute;
  } hst_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } hst_sts_t;

endpackage
`default_nettype wire

[sv/hst_ctrl.sv]
// Controller state machine: takes an item, then runs its execute cycle.
`default_nettype none
module hst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hst_pkg::hst_sts_t sts_i,
  output hst_pkg::hst_cmd_t cmd_o
);
  import hst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new item
        if (!sts_i.out_blocked) begin
          cmd_o.execute = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/hst_datapath.sv]
// Datapath: slot table, handle counter, live count and result register.
`default_nettype none
module hst_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hst_pkg::hst_cmd_t                   cmd_i,
  output hst_pkg::hst_sts_t                   sts_o,
  input  logic [hst_pkg::REQ_W-1:0]           req_type_i,
  input  logic [hst_pkg::HANDLE_W-1:0]        task_handle_i,
  input  logic signed [hst_pkg::EXIT_W-1:0]   exit_value_i,
  input  logic [hst_pkg::SLOTNUM_W-1:0]       slot_number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic [hst_pkg::SLOT_OUT_W-1:0]      slot_out_o,
  output logic [hst_pkg::HANDLE_W-1:0]        handle_out_o,
  output logic [hst_pkg::STATE_W-1:0]         state_out_o,
  output logic signed [hst_pkg::EXIT_W-1:0]   exit_out_o,
  output logic [hst_pkg::LIVE_OUT_W-1:0]      live_count_o
);
  import hst_pkg::*;

  // Captured request
  logic [REQ_W-1:0]     req_q;
  logic [HANDLE_W-1:0]  hnd_q;
  logic [EXIT_W-1:0]    code_q;
  logic [SLOTNUM_W-1:0] num_q;

  // Slot table
  logic [STATE_W-1:0]  st_q [SLOTS];
  logic [HANDLE_W-1:0] hd_q [SLOTS];
  logic [EXIT_W-1:0]   ex_q [SLOTS];
  logic [HANDLE_W-1:0] cnt_q;
  logic [LIVE_W-1:0]   live_q, live_d;

  // Result register
  logic                  vld_q;
  logic                  ok_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [HANDLE_W-1:0]   rhd_q;
  logic [STATE_W-1:0]    rst_q;
  logic [EXIT_W-1:0]     rex_q;
  logic [LIVE_OUT_W-1:0] rlive_q;

  logic              hit, fre;
  logic [SLOT_W-1:0] hit_idx, fre_idx, sel;
  logic              sel_ok;
  logic [STATE_W-1:0]  cur_st, new_st;
  logic [HANDLE_W-1:0] cur_hd, new_hd;
  logic [EXIT_W-1:0]   cur_ex, new_ex;
  logic              inc, dec, bump, wr;

  assign sts_o.out_blocked = vld_q && out_stall_i;

  // Lowest matching live slot and lowest free slot
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    fre = 1'b0;
    fre_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (st_q[i] != ST_FREE && hd_q[i] == hnd_q) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (st_q[i] == ST_FREE) begin
        fre = 1'b1;
        fre_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    sel_ok = 1'b0;
    sel = hit_idx;
    unique case (req_q) inside
      REQ_ALLOC: begin
        sel_ok = fre;
        sel = fre_idx;
      end
      REQ_FIND, REQ_SET_EXIT, REQ_FREE, REQ_MARK_RUN: begin
        sel_ok = hit;
      end
      REQ_READ: begin
        sel_ok = (int'(num_q) < SLOTS);
        sel = num_q[SLOT_W-1:0];
      end
      default: sel_ok = 1'b0;
    endcase
  end

  assign cur_st = st_q[sel];
  assign cur_hd = hd_q[sel];
  assign cur_ex = ex_q[sel];

  always_comb begin
    new_st = cur_st;
    new_hd = cur_hd;
    new_ex = cur_ex;
    inc = 1'b0;
    dec = 1'b0;
    bump = 1'b0;
    unique case (req_q) inside
      REQ_ALLOC: begin
        new_st = ST_LOADING;
        new_hd = cnt_q;
        new_ex = '0;
        bump = 1'b1;
      end
      REQ_SET_EXIT: begin
        new_st = ST_EXITED;
        new_ex = code_q;
        inc = (cur_st == ST_LOADING);
      end
      REQ_FREE: begin
        new_st = ST_FREE;
        new_hd = '0;
        dec = (cur_st == ST_RUNNING) || (cur_st == ST_EXITED);
      end
      REQ_MARK_RUN: begin
        if (cur_st == ST_LOADING) begin
          new_st = ST_RUNNING;
          inc = 1'b1;
        end
      end
      REQ_FIND, REQ_READ: begin
        new_st = cur_st;
      end
      default: new_st = cur_st;
    endcase
  end

  assign wr = cmd_i.execute && sel_ok;
  assign live_d = live_q + LIVE_W'(inc) - LIVE_W'(dec);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      hnd_q  <= task_handle_i;
      code_q <= $unsigned(exit_value_i);
      num_q  <= slot_number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= ST_FREE;
        hd_q[i] <= '0;
        ex_q[i] <= '0;
      end
      cnt_q  <= HANDLE_RESET;
      live_q <= '0;
    end else if (wr) begin
      st_q[sel] <= new_st;
      hd_q[sel] <= new_hd;
      ex_q[sel] <= new_ex;
      live_q    <= live_d;
      if (bump) begin
        cnt_q <= cnt_q + HANDLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.execute || (vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      ok_q    <= sel_ok;
      slot_q  <= sel_ok ? SLOT_OUT_W'(sel) : '0;
      rhd_q   <= sel_ok ? new_hd : '0;
      rst_q   <= sel_ok ? new_st : ST_FREE;
      rex_q   <= sel_ok ? new_ex : '0;
      rlive_q <= LIVE_OUT_W'(sel_ok ? live_d : live_q);
    end
  end

  assign out_valid_o  = vld_q;
  assign ok_o         = ok_q;
  assign slot_out_o   = slot_q;
  assign handle_out_o = rhd_q;
  assign state_out_o  = rst_q;
  assign exit_out_o   = $signed(rex_q);
  assign live_count_o = rlive_q;

endmodule
`default_nettype wire

[sv/handle_slot_table.sv]
// Handle slot table: task slots with handle allocation, lookup and state changes.
// Each request item is captured, then executed once the result register is free;
//   the execute step compares every slot's handle and writes the table, and one
//   item is executed before the next is taken; a stalled result delays it.
// Reset: asynchronous, active low; all slots free with handle and exit code zero,
//   handle counter at one, no result pending.
`default_nettype none
module handle_slot_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hst_pkg::REQ_W-1:0]           req_type_i,
  input  logic [hst_pkg::HANDLE_W-1:0]        task_handle_i,
  input  logic signed [hst_pkg::EXIT_W-1:0]   exit_value_i,
  input  logic [hst_pkg::SLOTNUM_W-1:0]       slot_number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic [hst_pkg::SLOT_OUT_W-1:0]      slot_out_o,
  output logic [hst_pkg::HANDLE_W-1:0]        handle_out_o,
  output logic [hst_pkg::STATE_W-1:0]         state_out_o,
  output logic signed [hst_pkg::EXIT_W-1:0]   exit_out_o,
  output logic [hst_pkg::LIVE_OUT_W-1:0]      live_count_o
);
  import hst_pkg::*;

  hst_cmd_t cmd;
  hst_sts_t sts;

  // Controller: take one item, then fire the execute cycle once the result
  // register is free (a waiting result holds the execute cycle, and with it
  // any further intake).
  hst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: hold the table, search it, apply the request and register the item.
  hst_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .task_handle_i (task_handle_i),
    .exit_value_i  (exit_value_i),
    .slot_number_i (slot_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .slot_out_o    (slot_out_o),
    .handle_out_o  (handle_out_o),
    .state_out_o   (state_out_o),
    .exit_out_o    (exit_out_o),
    .live_count_o  (live_count_o)
  );

endmodule
`default_nettype wire

[sv/hst_checker.sv]
// Port-level checker for the handle slot table, bound to the top level.
`default_nettype none
module hst_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                ok_o,
  input logic [hst_pkg::SLOT_OUT_W-1:0]      slot_out_o,
  input logic [hst_pkg::HANDLE_W-1:0]        handle_out_o,
  input logic [hst_pkg::STATE_W-1:0]         state_out_o,
  input logic signed [hst_pkg::EXIT_W-1:0]   exit_out_o,
  input logic [hst_pkg::LIVE_OUT_W-1:0]      live_count_o
);
  import hst_pkg::*;

  // a stalled result item stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(handle_out_o)
      && $stable(live_count_o) && $stable(ok_o))
    else $error("stalled result item changed");

  // one item at a time: intake closes right after an item is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken before the first was executed");

  // a failed request reports an empty slot
  a_not_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> handle_out_o == '0 && state_out_o == ST_FREE
      && exit_out_o == '0 && slot_out_o == '0)
    else $error("not-ok result carries slot data");

  // live count never exceeds the table size
  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(live_count_o) <= SLOTS)
    else $error("live count beyond table size");

endmodule

bind handle_slot_table hst_checker u_hst_checker (.*);
`default_nettype wire

[test/handle_slot_table_test.sv]
// Self-checking testbench of the handle slot table: directed rows, then random requests.
`default_nettype none
module handle_slot_table_test;
  import hst_pkg::*;

  // Request codes the block does not define; it must refuse them.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 260;
  localparam int HOLD_CYCLES      = 40;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct packed {
    logic [REQ_W-1:0]     req;
    logic [HANDLE_W-1:0]  task_handle;
    logic [EXIT_W-1:0]    exit_value;
    logic [SLOTNUM_W-1:0] slot_number;
  } req_item_t;

  typedef struct packed {
    logic                  ok;
    logic [SLOT_OUT_W-1:0] slot;
    logic [HANDLE_W-1:0]   handle;
    logic [STATE_W-1:0]    state;
    logic [EXIT_W-1:0]     stored_code;
    logic [LIVE_OUT_W-1:0] live;
  } slot_result_t;

  typedef struct {
    req_item_t    item;
    int           reps;
    bit           fixed;
    slot_result_t want;
  } dir_row_t;

  // Clock, reset and the block's ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] req_type = '0;
  logic [HANDLE_W-1:0] task_handle = '0;
  logic signed [EXIT_W-1:0] exit_value = '0;
  logic [SLOTNUM_W-1:0] slot_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [HANDLE_W-1:0] handle_out;
  logic [STATE_W-1:0] state_out;
  logic signed [EXIT_W-1:0] exit_out;
  logic [LIVE_OUT_W-1:0] live_count;

  // Shadow copy of the slot table, advanced once per accepted item
  logic [STATE_W-1:0]  slot_st   [SLOTS];
  logic [HANDLE_W-1:0] slot_hdl  [SLOTS];
  logic [EXIT_W-1:0]   slot_code [SLOTS];
  logic [HANDLE_W-1:0] next_handle;

  slot_result_t pending_results [$];
  slot_result_t due;
  dir_row_t dir_rows [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full = 0;
  int n_miss = 0;
  int cycle_count = 0;

  handle_slot_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .task_handle_i (task_handle),
    .exit_value_i  (exit_value),
    .slot_number_i (slot_number),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .ok_o          (ok),
    .slot_out_o    (slot_out),
    .handle_out_o  (handle_out),
    .state_out_o   (state_out),
    .exit_out_o    (exit_out),
    .live_count_o  (live_count)
  );

  always #2 clk_i = ~clk_i;

  // Lowest non-free slot holding the handle, or -1; free slots never match.
  function automatic int lookup_handle(logic [HANDLE_W-1:0] hdl);
    int hit;
    hit = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_st[i] != ST_FREE && slot_hdl[i] == hdl) hit = i;
    end
    return hit;
  endfunction

  // Apply one request to the shadow table and return the result it must give.
  function automatic slot_result_t apply_request(req_item_t it);
    slot_result_t res;
    int hit;
    int live;
    res = '0;
    hit = -1;
    live = 0;
    case (it.req)
      REQ_ALLOC: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_st[i] == ST_FREE) hit = i;
        end
        if (hit >= 0) begin
          slot_hdl[hit] = next_handle;
          next_handle = next_handle + 1;
          slot_st[hit] = ST_LOADING;
          slot_code[hit] = '0;
        end
      end
      REQ_FIND: hit = lookup_handle(it.task_handle);
      REQ_SET_EXIT: begin
        hit = lookup_handle(it.task_handle);
        if (hit >= 0) begin
          slot_st[hit] = ST_EXITED;
          slot_code[hit] = it.exit_value;
        end
      end
      REQ_FREE: begin
        hit = lookup_handle(it.task_handle);
        if (hit >= 0) begin
          slot_st[hit] = ST_FREE;
          slot_hdl[hit] = '0;
        end
      end
      REQ_READ: if (int'(it.slot_number) < SLOTS) hit = int'(it.slot_number);
      REQ_MARK_RUN: begin
        hit = lookup_handle(it.task_handle);
        if (hit >= 0 && slot_st[hit] == ST_LOADING) slot_st[hit] = ST_RUNNING;
      end
      default: ;
    endcase
    if (hit >= 0) begin
      res.ok = 1'b1;
      res.slot = hit[SLOT_OUT_W-1:0];
      res.handle = slot_hdl[hit];
      res.state = slot_st[hit];
      res.stored_code = slot_code[hit];
    end else if (it.req == REQ_ALLOC) begin
      n_full++;
    end else if (it.req != REQ_READ && it.req <= REQ_MARK_RUN) begin
      n_miss++;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_st[i] == ST_RUNNING || slot_st[i] == ST_EXITED) live++;
    end
    res.live = live[LIVE_OUT_W-1:0];
    return res;
  endfunction

  function automatic slot_result_t result_of(logic okv, logic [SLOT_OUT_W-1:0] s,
                                             logic [HANDLE_W-1:0] h, logic [STATE_W-1:0] st,
                                             logic [EXIT_W-1:0] code, logic [LIVE_OUT_W-1:0] lv);
    slot_result_t r;
    r = '{okv, s, h, st, code, lv};
    return r;
  endfunction

  task automatic add_row(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] hdl,
                         logic [EXIT_W-1:0] code, logic [SLOTNUM_W-1:0] num,
                         int reps, bit fixed, slot_result_t want);
    dir_row_t row;
    row.item = '{req, hdl, code, num};
    row.reps = reps;
    row.fixed = fixed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Random request: mostly live handles so lookups hit, with stale and wild ones mixed in.
  function automatic req_item_t random_request();
    req_item_t it;
    int pick;
    int hsel;
    int live_idx [$];
    pick = $urandom_range(99);
    if (pick < 22) it.req = REQ_ALLOC;
    else if (pick < 36) it.req = REQ_FIND;
    else if (pick < 50) it.req = REQ_SET_EXIT;
    else if (pick < 64) it.req = REQ_FREE;
    else if (pick < 78) it.req = REQ_MARK_RUN;
    else if (pick < 94) it.req = REQ_READ;
    else if (pick < 97) it.req = pick[0] ? REQ_SPARE_7 : REQ_SPARE_6;
    else it.req = REQ_W'($urandom_range(0, 7));
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_st[i] != ST_FREE) live_idx.push_back(i);
    end
    hsel = $urandom_range(9);
    if (hsel < 8 && live_idx.size() > 0)
      it.task_handle = slot_hdl[live_idx[$urandom_range(live_idx.size() - 1)]];
    else if (hsel < 9)
      it.task_handle = $urandom_range(0, next_handle + 1);
    else
      it.task_handle = $urandom;
    it.exit_value = $urandom;
    if ($urandom_range(4) != 0) it.slot_number = SLOTNUM_W'($urandom_range(0, SLOTS - 1));
    else it.slot_number = SLOTNUM_W'($urandom_range(SLOTS, 255));
    return it;
  endfunction

  // Offer one item, hold it until taken, then record what it must produce.
  task automatic offer_item(req_item_t it, bit fixed, slot_result_t want);
    slot_result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      req_type = $urandom;
      task_handle = $urandom;
      exit_value = $urandom;
      slot_number = $urandom;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    req_type = it.req;
    task_handle = it.task_handle;
    exit_value = it.exit_value;
    slot_number = it.slot_number;
    do @(posedge clk_i); while (in_stall);
    pred = apply_request(it);
    pending_results.push_back(fixed ? want : pred);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s in result %0d: expected %h, got %h",
                 fname, n_results, want, got);
    end
  endtask

  // Receiver: a long hold-off when asked for, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result item taken with the oldest one outstanding.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing outstanding");
      end else begin
        due = pending_results.pop_front();
        check_field("ok", 32'(due.ok), 32'(ok));
        check_field("slot_out", 32'(due.slot), 32'(slot_out));
        check_field("handle_out", due.handle, handle_out);
        check_field("state_out", 32'(due.state), 32'(state_out));
        check_field("exit_out", due.stored_code, exit_out);
        check_field("live_count", 32'(due.live), 32'(live_count));
        n_results++;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i] = ST_FREE;
      slot_hdl[i] = '0;
      slot_code[i] = '0;
    end
    next_handle = HANDLE_RESET;

    // Directed rows; expectations typed in where they are plain, else predicted.
    add_row(REQ_READ, '0, '0, 8'd0, 1, 1, result_of(1, 0, 0, ST_FREE, 0, 0));
    add_row(REQ_READ, '0, '0, 8'd16, 1, 1, result_of(0, 0, 0, ST_FREE, 0, 0));
    add_row(REQ_READ, '1, '1, 8'd255, 1, 1, result_of(0, 0, 0, ST_FREE, 0, 0));
    add_row(REQ_SPARE_6, 32'hFFFF_FFFF, 32'h8000_0000, 8'd0, 1, 1,
            result_of(0, 0, 0, ST_FREE, 0, 0));
    add_row(REQ_SPARE_7, 32'd1, 32'h7FFF_FFFF, 8'd3, 1, 1,
            result_of(0, 0, 0, ST_FREE, 0, 0));
    add_row(REQ_ALLOC, '0, '0, '0, 1, 1, result_of(1, 0, 1, ST_LOADING, 0, 0));
    add_row(REQ_ALLOC, '0, '0, '0, 1, 1, result_of(1, 1, 2, ST_LOADING, 0, 0));
    add_row(REQ_MARK_RUN, 32'd1, '0, '0, 1, 1, result_of(1, 0, 1, ST_RUNNING, 0, 1));
    add_row(REQ_SET_EXIT, 32'd2, 32'h8000_0000, '0, 1, 1,
            result_of(1, 1, 2, ST_EXITED, 32'h8000_0000, 2));
    add_row(REQ_SET_EXIT, 32'd1, 32'h7FFF_FFFF, '0, 1, 1,
            result_of(1, 0, 1, ST_EXITED, 32'h7FFF_FFFF, 2));
    // Mark running leaves an exited slot alone but still reports it
    add_row(REQ_MARK_RUN, 32'd1, '0, '0, 1, 1,
            result_of(1, 0, 1, ST_EXITED, 32'h7FFF_FFFF, 2));
    // Free keeps the exit code and clears the handle
    add_row(REQ_FREE, 32'd2, '0, '0, 1, 1, result_of(1, 1, 0, ST_FREE, 32'h8000_0000, 1));
    add_row(REQ_FIND, 32'd2, '0, '0, 1, 1, result_of(0, 0, 0, ST_FREE, 0, 1));
    // A freed slot has handle zero yet must not match it
    add_row(REQ_FIND, 32'd0, '0, '0, 1, 1, result_of(0, 0, 0, ST_FREE, 0, 1));
    add_row(REQ_ALLOC, '0, '0, '0, SLOTS - 1, 0, '0);
    // Table full: refused, counter held
    add_row(REQ_ALLOC, '0, '0, '0, 1, 1, result_of(0, 0, 0, ST_FREE, 0, 1));
    add_row(REQ_FREE, 32'd1, '0, '0, 1, 0, '0);
    add_row(REQ_ALLOC, '0, '0, '0, 1, 0, '0);
    add_row(REQ_MARK_RUN, 32'd3, '0, '0, 1, 0, '0);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) offer_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].want);
    end
    drain_results();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 77 : (ph == 3) ? 17 : 0;
      stall_pct = (ph == 2) ? 77 : (ph == 3) ? 17 : 0;
      // Hold the output off while items keep coming, so the input backs up
      if (ph == 0) hold_request = 1;
      repeat (RANDOM_PER_PHASE) offer_item(random_request(), 0, '0);
      // Pause the sender until every result item has come back
      drain_results();
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked under four idling phases",
             n_items, n_results);
    $display("%0d allocations refused on a full table, %0d handle lookups missed",
             n_full, n_miss);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
